// ===== hw/rtl/rse_pkg.sv =====
// rse_pkg: shared constants for the reverse polish stack evaluator
// holds data widths, stack depth, item mode codes and status codes
// no dependencies
package rse_pkg;

  localparam int DATA_W      = 64;
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ITER_W      = $clog2(DATA_W);

  localparam int MODE_W    = 3;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 80;

  localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

endpackage

// ===== hw/rtl/rpn_stack_evaluator_unit.sv =====
// rpn_stack_evaluator_unit: reverse polish integer evaluator on a 64-bit stack
// depends on rse_pkg and rse_ram
// one shared 65-bit adder does add, subtract, shift-add multiply and restoring divide

// One item in, one item out. The stack top sits in a register and the entries
// below it in a ram with a registered read port, so an operator or a pop waits
// for the ram read in the operand read state. All arithmetic runs through a
// single 65-bit adder under a small sequencer, one bit per cycle for multiply
// and divide. Push, ignored modes, overflow, underflow and a pop of the last
// entry go straight to the final state; add, subtract, any other pop and a zero
// divisor first pass the operand read state; multiply then runs 64 adder passes
// and divide two magnitude passes, 64 quotient bits and one sign pass. The input
// is not ready while an item is being worked on; a finished item moves into the
// output register as soon as that is free, and until then the input stays not
// ready. Reset clears the state, the entry count and the output valid.
module rpn_stack_evaluator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operand_value [63:0]
  input  logic [rse_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // mode [2:0]
  input  logic [rse_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_value [63:0], stack_count [71:64], status [73:72], zero [79:74]
  output logic [rse_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  import rse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPRD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DVA  = 3'd3;
  localparam logic [2:0] S_DVB  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_NEG  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [DATA_W-1:0]   top_val;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   opa;
  logic [DATA_W-1:0]   opb;
  logic [ITER_W-1:0]   iter;
  logic [MODE_W-1:0]   op_mode;
  logic                neg_q;
  logic                pop_ok;
  logic                pop_load;
  logic [DATA_W-1:0]   res_val;
  logic [STATUS_W-1:0] res_stat;

  logic                accept;
  logic                ram_wr_en;
  logic [DATA_W-1:0]   ram_rd_data;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [ADDR_W-1:0]   ram_wr_addr;

  logic [DATA_W-1:0]   add_x;
  logic [DATA_W-1:0]   add_y;
  logic                add_sub;
  logic [DATA_W:0]     add_sum;
  logic [DATA_W-1:0]   rem_shift;
  logic                out_free;
  logic [DATA_W-1:0]   out_val;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // the entry under the top is always at count-2
  assign ram_rd_addr = ADDR_W'(count - CNT_W'(2));
  assign ram_wr_addr = ADDR_W'(count - CNT_W'(1));
  assign ram_wr_en   = accept && (s_axis_tuser == MODE_PUSH) && (count != '0) &&
                       (count < CNT_W'(STACK_DEPTH));

  rse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (top_val),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rem_shift = {acc[DATA_W-2:0], opa[DATA_W-1]};

  // operand select for the shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      S_OPRD: begin
        add_x   = ram_rd_data;
        add_y   = top_val;
        add_sub = (op_mode == MODE_SUB);
      end
      S_MUL: begin
        add_x = acc;
        add_y = opa;
      end
      S_DVA: begin
        add_y   = opa;
        add_sub = 1'b1;
      end
      S_DVB: begin
        add_y   = opb;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = rem_shift;
        add_y   = opb;
        add_sub = 1'b1;
      end
      S_NEG: begin
        add_y   = opa;
        add_sub = neg_q;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}} +
                   (DATA_W + 1)'(add_sub);

  assign out_val = pop_ok ? res_val : ((count != '0) ? top_val : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the final state loads a new item when the output is free
      if (m_axis_tvalid && m_axis_tready && (state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_mode <= s_axis_tuser;
            case (s_axis_tuser)
              MODE_PUSH: begin
                pop_ok   <= 1'b0;
                pop_load <= 1'b0;
                state    <= S_FIN;
                if (count >= CNT_W'(STACK_DEPTH)) begin
                  res_stat <= ST_OVERFLOW;
                end else begin
                  res_stat <= ST_OK;
                  top_val  <= s_axis_tdata;
                  count    <= count + CNT_W'(1);
                end
              end
              MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                pop_ok   <= 1'b0;
                pop_load <= 1'b0;
                if (count < CNT_W'(2)) begin
                  res_stat <= ST_UNDERFLOW;
                  state    <= S_FIN;
                end else begin
                  res_stat <= ST_OK;
                  state    <= S_OPRD;
                end
              end
              MODE_POP: begin
                if (count == '0) begin
                  pop_ok   <= 1'b0;
                  pop_load <= 1'b0;
                  res_stat <= ST_UNDERFLOW;
                  state    <= S_FIN;
                end else begin
                  pop_ok   <= 1'b1;
                  res_stat <= ST_OK;
                  res_val  <= top_val;
                  count    <= count - CNT_W'(1);
                  // new top comes from the ram read issued this cycle
                  pop_load <= (count >= CNT_W'(2));
                  state    <= (count >= CNT_W'(2)) ? S_OPRD : S_FIN;
                end
              end
              default: begin
                pop_ok   <= 1'b0;
                pop_load <= 1'b0;
                res_stat <= ST_OK;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_OPRD: begin
          if (pop_load) begin
            top_val <= ram_rd_data;
            state   <= S_FIN;
          end else begin
            case (op_mode)
              MODE_ADD, MODE_SUB: begin
                top_val <= add_sum[DATA_W-1:0];
                count   <= count - CNT_W'(1);
                state   <= S_FIN;
              end
              MODE_MUL: begin
                acc   <= '0;
                opa   <= ram_rd_data;
                opb   <= top_val;
                iter  <= '0;
                state <= S_MUL;
              end
              default: begin
                if (top_val == '0) begin
                  res_stat <= ST_DIVZERO;
                  state    <= S_FIN;
                end else begin
                  acc   <= '0;
                  opa   <= ram_rd_data;
                  opb   <= top_val;
                  neg_q <= ram_rd_data[DATA_W-1] ^ top_val[DATA_W-1];
                  state <= S_DVA;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          if (opb[0]) begin
            acc <= add_sum[DATA_W-1:0];
          end
          opa  <= {opa[DATA_W-2:0], 1'b0};
          opb  <= {1'b0, opb[DATA_W-1:1]};
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(DATA_W - 1)) begin
            top_val <= opb[0] ? add_sum[DATA_W-1:0] : acc;
            count   <= count - CNT_W'(1);
            state   <= S_FIN;
          end
        end
        S_DVA: begin
          // magnitude of the dividend
          if (opa[DATA_W-1]) begin
            opa <= add_sum[DATA_W-1:0];
          end
          state <= S_DVB;
        end
        S_DVB: begin
          if (opb[DATA_W-1]) begin
            opb <= add_sum[DATA_W-1:0];
          end
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // carry out set means the shifted remainder is at least the divisor
          acc  <= add_sum[DATA_W] ? add_sum[DATA_W-1:0] : rem_shift;
          opa  <= {opa[DATA_W-2:0], add_sum[DATA_W]};
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(DATA_W - 1)) begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          top_val <= add_sum[DATA_W-1:0];
          count   <= count - CNT_W'(1);
          state   <= S_FIN;
        end
        default: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {(M_TDATA_W - DATA_W - COUNT_W - STATUS_W)'(0), res_stat,
                              COUNT_W'(count), out_val};
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rse_ram.sv =====
// rse_ram: generic single-write, single-read ram with registered read data
// used for the stack entries below the top of stack
// no dependencies
module rse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
